// ===== hw/rtl/afvt_pkg.sv =====
// package for the box versus frustum visibility test
// widths, item struct and constants shared by the interfaces, the plane cell and the top level
`default_nettype none
package afvt_pkg;

  localparam int COORD_W         = 16;
  localparam int NORM_W          = 16;
  localparam int NORM_FRAC       = 14;
  localparam int PROD_W          = COORD_W + NORM_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int PLANE_W         = 64;
  localparam int REG_COUNT       = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int PLANE_COUNT_DEF = 6;

  localparam int NX_LSB = 0;
  localparam int NY_LSB = 16;
  localparam int NZ_LSB = 32;
  localparam int D_LSB  = 48;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PLANE_W-1:0]        plane_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   invalid;
    logic   culled;
  } item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/afvt_if.sv =====
// valid/ready channel interfaces: box input, result output and register write
// depends on afvt_pkg
`default_nettype none
interface afvt_box_if;
  logic                   valid;
  logic                   ready;
  afvt_pkg::coord_t       min_x;
  afvt_pkg::coord_t       min_y;
  afvt_pkg::coord_t       min_z;
  afvt_pkg::coord_t       max_x;
  afvt_pkg::coord_t       max_y;
  afvt_pkg::coord_t       max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface afvt_res_if;
  logic valid;
  logic ready;
  logic visible;
  logic invalid_box;

  modport source (output valid, visible, invalid_box, input ready);
  modport sink   (input valid, visible, invalid_box, output ready);
endinterface

interface afvt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [afvt_pkg::CFG_IDX_W-1:0]   index;
  afvt_pkg::plane_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/afvt_cell.sv =====
// one plane cell: picks the p-vertex, multiplies, then sums and tests the sign
// two register stages with their own valid/ready; depends on afvt_pkg
`default_nettype none
module afvt_cell (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  afvt_pkg::plane_t   plane_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  afvt_pkg::item_t    in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output afvt_pkg::item_t    out_data_o
);
  import afvt_pkg::*;

  logic signed [NORM_W-1:0]  nx, ny, nz, offs;
  coord_t                    cx, cy, cz;

  logic                      a_valid_q, a_ready;
  item_t                     a_data_q;
  logic signed [PROD_W-1:0]  px_q, py_q, pz_q;
  logic signed [NORM_W-1:0]  d_q;

  logic                      b_valid_q, b_ready;
  item_t                     b_data_q, b_data_d;
  logic signed [SUM_W-1:0]   sum;

  assign nx   = plane_i[NX_LSB +: NORM_W];
  assign ny   = plane_i[NY_LSB +: NORM_W];
  assign nz   = plane_i[NZ_LSB +: NORM_W];
  assign offs = plane_i[D_LSB  +: NORM_W];

  // corner most aligned with the normal
  assign cx = nx[NORM_W-1] ? in_data_i.min_x : in_data_i.max_x;
  assign cy = ny[NORM_W-1] ? in_data_i.min_y : in_data_i.max_y;
  assign cz = nz[NORM_W-1] ? in_data_i.min_z : in_data_i.max_z;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_data_q <= in_data_i;
      px_q     <= nx * cx;
      py_q     <= ny * cy;
      pz_q     <= nz * cz;
      d_q      <= offs;
    end
    if (b_ready && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

  always_comb begin
    sum = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q)
        + SUM_W'($signed({d_q, {NORM_FRAC{1'b0}}}));
    b_data_d        = a_data_q;
    b_data_d.culled = a_data_q.culled | sum[SUM_W-1];
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/aabb_frustum_visibility_test.sv =====
// box versus view frustum visibility test, top level
// plane registers, invalid box check and the chain of afvt_cell; depends on afvt_pkg, afvt_if
//
// usage:
//   box_i  : one box per item (min and max corners, signed, 4 fraction bits)
//   res_o  : one result per box, in order: visible and invalid_box
//   cfg_i  : register writes, index 0..5 = left, right, bottom, top, near, far;
//            always ready, writes to higher indexes are dropped; write only when idle
// each plane register packs normal x, y, z (Q1.14) in bits 47:0 and distance in 63:48
// latency: 2 * PLANE_COUNT cycles from box accept to result valid, set by the two
//   register stages (multiply, then sum and sign) in each plane cell
// throughput: one box per cycle; a full chain of cells holds 2 * PLANE_COUNT boxes
// stall: when res_o is not taken, the chain fills stage by stage and box_i.ready
//   drops only once every stage is occupied
// reset: all plane registers clear to zero (a zero plane never culls) and the chain empties
// planes beyond the sixth have no register and never cull
`default_nettype none
module aabb_frustum_visibility_test #(
  parameter int PLANE_COUNT = afvt_pkg::PLANE_COUNT_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  afvt_box_if.sink   box_i,
  afvt_res_if.source res_o,
  afvt_cfg_if.sink   cfg_i
);
  import afvt_pkg::*;

  plane_t plane_q [REG_COUNT];

  logic   chain_valid [PLANE_COUNT+1];
  logic   chain_ready [PLANE_COUNT+1];
  item_t  chain_data  [PLANE_COUNT+1];
  item_t  box_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(REG_COUNT))) begin
      plane_q[cfg_i.index] <= cfg_i.data;
    end
  end

  always_comb begin
    box_item.min_x   = box_i.min_x;
    box_item.min_y   = box_i.min_y;
    box_item.min_z   = box_i.min_z;
    box_item.max_x   = box_i.max_x;
    box_item.max_y   = box_i.max_y;
    box_item.max_z   = box_i.max_z;
    box_item.invalid = (box_i.min_x > box_i.max_x) || (box_i.min_y > box_i.max_y)
                    || (box_i.min_z > box_i.max_z);
    box_item.culled  = 1'b0;
  end

  assign chain_data[0]  = box_item;
  assign chain_valid[0] = box_i.valid;
  assign box_i.ready    = chain_ready[0];

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
    plane_t plane;
    if (k < REG_COUNT) begin : g_reg
      assign plane = plane_q[k];
    end else begin : g_zero
      assign plane = '0;
    end

    afvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .plane_i     (plane),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_data_i   (chain_data[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_data_o  (chain_data[k+1])
    );
  end

  assign chain_ready[PLANE_COUNT] = res_o.ready;
  assign res_o.valid       = chain_valid[PLANE_COUNT];
  assign res_o.invalid_box = chain_data[PLANE_COUNT].invalid;
  assign res_o.visible     = !chain_data[PLANE_COUNT].invalid
                          && !chain_data[PLANE_COUNT].culled;

  a_invalid_not_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.visible && res_o.invalid_box))
    else $error("invalid box reported visible");

  a_cfg_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && (cfg_i.index >= CFG_IDX_W'(REG_COUNT))) |=>
      $stable(plane_q[0]) && $stable(plane_q[REG_COUNT-1]))
    else $error("plane register changed on out of range write");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled while the output is free");

endmodule
`default_nettype wire
